>>> hdl/gcdlcm_pkg.sv
// ----------------------------------------------------------------------------
// gcdlcm_pkg
// shared constants for the gcd / lcm pipeline
// ----------------------------------------------------------------------------
package gcdlcm_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam logic FUNC_GCD = 1'b0;
   localparam logic FUNC_LCM = 1'b1;

endpackage

>>> hdl/gcdlcm_req_if.sv
// ----------------------------------------------------------------------------
// gcdlcm_req_if
// request channel: function select and two signed operands
// ----------------------------------------------------------------------------
interface gcdlcm_req_if #(
   parameter int DATA_WIDTH = gcdlcm_pkg::DATA_WIDTH_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic signed [DATA_WIDTH-1:0] operand_a;
   logic signed [DATA_WIDTH-1:0] operand_b;

   modport source (output valid, func, operand_a, operand_b, input ready);
   modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

>>> hdl/gcdlcm_rsp_if.sv
// ----------------------------------------------------------------------------
// gcdlcm_rsp_if
// response channel: saturated result and overflow flag
// ----------------------------------------------------------------------------
interface gcdlcm_rsp_if #(
   parameter int DATA_WIDTH = gcdlcm_pkg::DATA_WIDTH_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-2:0] result;
   logic                  overflow;

   modport source (output valid, result, overflow, input ready);
   modport sink   (input valid, result, overflow, output ready);
endinterface

>>> hdl/gcdlcm_gcd_step.sv
// ----------------------------------------------------------------------------
// gcdlcm_gcd_step
// one registered step of the binary gcd reduction
// ----------------------------------------------------------------------------
module gcdlcm_gcd_step #(
   parameter int DATA_WIDTH = gcdlcm_pkg::DATA_WIDTH_DEFAULT,
   parameter int K_WIDTH    = 6,
   parameter int SIDE_WIDTH = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  valid_i,
   input  logic [DATA_WIDTH-1:0] x_i,
   input  logic [DATA_WIDTH-1:0] y_i,
   input  logic [K_WIDTH-1:0]    k_i,
   input  logic [SIDE_WIDTH-1:0] side_i,
   output logic                  valid_o,
   output logic [DATA_WIDTH-1:0] x_o,
   output logic [DATA_WIDTH-1:0] y_o,
   output logic [K_WIDTH-1:0]    k_o,
   output logic [SIDE_WIDTH-1:0] side_o
);
   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] x_ff, x_in;
   logic [DATA_WIDTH-1:0] y_ff, y_in;
   logic [K_WIDTH-1:0]    k_ff, k_in;
   logic [SIDE_WIDTH-1:0] side_ff;
   logic [DATA_WIDTH-1:0] diff;
   logic                  x_ge_y;

   always_comb begin
      x_ge_y = (x_i >= y_i);
      diff   = x_ge_y ? (x_i - y_i) : (y_i - x_i);
      x_in   = x_i;
      y_in   = y_i;
      k_in   = k_i;
      if ((x_i == '0) || (y_i == '0)) begin
         // finished, hold
      end else if (!x_i[0] && !y_i[0]) begin
         x_in = x_i >> 1;
         y_in = y_i >> 1;
         k_in = k_i + K_WIDTH'(1);
      end else if (!x_i[0]) begin
         x_in = x_i >> 1;
      end else if (!y_i[0]) begin
         y_in = y_i >> 1;
      end else if (x_ge_y) begin
         x_in = diff >> 1;
      end else begin
         y_in = diff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         k_ff    <= k_in;
         side_ff <= side_i;
      end
   end

   assign valid_o = valid_ff;
   assign x_o     = x_ff;
   assign y_o     = y_ff;
   assign k_o     = k_ff;
   assign side_o  = side_ff;
endmodule

>>> hdl/gcdlcm_div_step.sv
// ----------------------------------------------------------------------------
// gcdlcm_div_step
// one registered restoring-division step, one quotient bit
// ----------------------------------------------------------------------------
module gcdlcm_div_step #(
   parameter int DATA_WIDTH = gcdlcm_pkg::DATA_WIDTH_DEFAULT,
   parameter int SIDE_WIDTH = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  valid_i,
   input  logic [DATA_WIDTH-1:0] divisor_i,
   input  logic [DATA_WIDTH-1:0] rem_i,
   input  logic [DATA_WIDTH-1:0] quo_i,
   input  logic [SIDE_WIDTH-1:0] side_i,
   output logic                  valid_o,
   output logic [DATA_WIDTH-1:0] divisor_o,
   output logic [DATA_WIDTH-1:0] rem_o,
   output logic [DATA_WIDTH-1:0] quo_o,
   output logic [SIDE_WIDTH-1:0] side_o
);
   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] divisor_ff;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [SIDE_WIDTH-1:0] side_ff;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH:0]   sub;
   logic                  fits;

   always_comb begin
      trial  = {rem_i, quo_i[DATA_WIDTH-1]};
      sub    = trial - {1'b0, divisor_i};
      // trial stays below twice the divisor, so the top bit is the borrow
      fits   = !sub[DATA_WIDTH];
      rem_in = fits ? sub[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      quo_in = {quo_i[DATA_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
      if (advance) begin
         divisor_ff <= divisor_i;
         rem_ff     <= rem_in;
         quo_ff     <= quo_in;
         side_ff    <= side_i;
      end
   end

   assign valid_o   = valid_ff;
   assign divisor_o = divisor_ff;
   assign rem_o     = rem_ff;
   assign quo_o     = quo_ff;
   assign side_o    = side_ff;
endmodule

>>> hdl/integer_gcd_lcm_unit.sv
// ----------------------------------------------------------------------------
// integer_gcd_lcm_unit
// gcd or lcm of two signed operand magnitudes, saturating, fully pipelined
// ----------------------------------------------------------------------------
// A new item is accepted every cycle while no result waits at the output; each
// item passes through a register for the magnitudes, 2*DATA_WIDTH binary-gcd
// steps, a register that restores the common power of two, DATA_WIDTH
// restoring-divide steps for |a|/gcd, a multiply register and the output
// register. The whole pipeline holds while a result waits.
module integer_gcd_lcm_unit #(
   parameter int DATA_WIDTH = gcdlcm_pkg::DATA_WIDTH_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   gcdlcm_req_if.sink   req_ch,
   gcdlcm_rsp_if.source rsp_ch
);
   localparam int W       = DATA_WIDTH;
   localparam int K_WIDTH = $clog2(W + 1);
   localparam int GSTEPS  = 2 * W;
   localparam int GSIDE   = 2 + 2 * W;   // func, zero, ma, mb
   localparam int DSIDE   = 2 + W;       // func, zero, mb

   logic advance;
   logic out_valid_ff;

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   // magnitudes
   logic [W-1:0] ma, mb;
   assign ma = req_ch.operand_a[W-1] ? (~req_ch.operand_a + W'(1)) : req_ch.operand_a;
   assign mb = req_ch.operand_b[W-1] ? (~req_ch.operand_b + W'(1)) : req_ch.operand_b;

   logic             g_valid [0:GSTEPS];
   logic [W-1:0]     g_x     [0:GSTEPS];
   logic [W-1:0]     g_y     [0:GSTEPS];
   logic [K_WIDTH-1:0] g_k   [0:GSTEPS];
   logic [GSIDE-1:0] g_side  [0:GSTEPS];

   logic             in_valid_ff;
   logic [W-1:0]     in_a_ff, in_b_ff;
   logic             in_func_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_ch.valid;
      end
      if (advance) begin
         in_a_ff    <= ma;
         in_b_ff    <= mb;
         in_func_ff <= req_ch.func;
      end
   end

   assign g_valid[0] = in_valid_ff;
   assign g_x[0]     = in_a_ff;
   assign g_y[0]     = in_b_ff;
   assign g_k[0]     = '0;
   assign g_side[0]  = {in_func_ff, (in_a_ff == '0) || (in_b_ff == '0), in_a_ff, in_b_ff};

   for (genvar i = 0; i < GSTEPS; i++) begin : g_gcd
      gcdlcm_gcd_step #(
         .DATA_WIDTH (W),
         .K_WIDTH    (K_WIDTH),
         .SIDE_WIDTH (GSIDE)
      ) u_step (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .valid_i (g_valid[i]),
         .x_i     (g_x[i]),
         .y_i     (g_y[i]),
         .k_i     (g_k[i]),
         .side_i  (g_side[i]),
         .valid_o (g_valid[i+1]),
         .x_o     (g_x[i+1]),
         .y_o     (g_y[i+1]),
         .k_o     (g_k[i+1]),
         .side_o  (g_side[i+1])
      );
   end

   // restore common factor of two
   logic             gd_valid_ff;
   logic [W-1:0]     gd_g_ff, gd_g_in;
   logic [GSIDE-1:0] gd_side_ff;

   assign gd_g_in = (g_x[GSTEPS] | g_y[GSTEPS]) << g_k[GSTEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         gd_valid_ff <= 1'b0;
      end else if (advance) begin
         gd_valid_ff <= g_valid[GSTEPS];
      end
      if (advance) begin
         gd_g_ff    <= gd_g_in;
         gd_side_ff <= g_side[GSTEPS];
      end
   end

   logic             d_valid [0:W];
   logic [W-1:0]     d_div   [0:W];
   logic [W-1:0]     d_rem   [0:W];
   logic [W-1:0]     d_quo   [0:W];
   logic [DSIDE-1:0] d_side  [0:W];

   assign d_valid[0] = gd_valid_ff;
   assign d_div[0]   = gd_g_ff;
   assign d_rem[0]   = '0;
   assign d_quo[0]   = gd_side_ff[2*W-1:W];
   assign d_side[0]  = {gd_side_ff[GSIDE-1:GSIDE-2], gd_side_ff[W-1:0]};

   for (genvar j = 0; j < W; j++) begin : g_div
      gcdlcm_div_step #(
         .DATA_WIDTH (W),
         .SIDE_WIDTH (DSIDE)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_i   (d_valid[j]),
         .divisor_i (d_div[j]),
         .rem_i     (d_rem[j]),
         .quo_i     (d_quo[j]),
         .side_i    (d_side[j]),
         .valid_o   (d_valid[j+1]),
         .divisor_o (d_div[j+1]),
         .rem_o     (d_rem[j+1]),
         .quo_o     (d_quo[j+1]),
         .side_o    (d_side[j+1])
      );
   end

   // quotient times |b|
   logic           m_valid_ff;
   logic           m_func_ff;
   logic           m_zero_ff;
   logic [W-1:0]   m_g_ff;
   logic [2*W-1:0] m_prod_ff, m_prod_in;

   assign m_prod_in = {{W{1'b0}}, d_quo[W]} * {{W{1'b0}}, d_side[W][W-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff <= d_valid[W];
      end
      if (advance) begin
         m_func_ff <= d_side[W][DSIDE-1];
         m_zero_ff <= d_side[W][DSIDE-2];
         m_g_ff    <= d_div[W];
         m_prod_ff <= m_prod_in;
      end
   end

   // saturate and select
   logic [W-2:0] res_in;
   logic         ovf_in;
   logic [W-2:0] res_ff;
   logic         ovf_ff;

   always_comb begin
      if (m_func_ff == gcdlcm_pkg::FUNC_GCD) begin
         ovf_in = m_g_ff[W-1];
         res_in = ovf_in ? {(W-1){1'b1}} : m_g_ff[W-2:0];
      end else if (m_zero_ff) begin
         ovf_in = 1'b0;
         res_in = '0;
      end else begin
         ovf_in = (m_prod_ff[2*W-1:W-1] != '0);
         res_in = ovf_in ? {(W-1){1'b1}} : m_prod_ff[W-2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= m_valid_ff;
      end
      if (advance) begin
         res_ff <= res_in;
         ovf_ff <= ovf_in;
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.result   = res_ff;
   assign rsp_ch.overflow = ovf_ff;
endmodule

>>> dv/integer_gcd_lcm_unit_tb.sv
// ----------------------------------------------------------------------------
// integer_gcd_lcm_unit_tb
// drives signed operand pairs with gcd / lcm selects through the request
// channel, predicts the saturated result and overflow flag for each item and
// checks every response in order, with and without random sender and receiver idling
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module integer_gcd_lcm_unit_tb;

   localparam int DW = 32;
   localparam longint unsigned SAT_MAX = (64'd1 << (DW - 1)) - 1;
   localparam int PIPE_DEPTH = 3 * DW + 4;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic          func;
      logic [DW-1:0] operand_a;
      logic [DW-1:0] operand_b;
   } op_pair_type;

   typedef struct packed {
      logic [DW-2:0] result;
      logic          overflow;
   } gl_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gcdlcm_req_if #(.DATA_WIDTH(DW)) req_ch ();
   gcdlcm_rsp_if #(.DATA_WIDTH(DW)) rsp_ch ();

   integer_gcd_lcm_unit #(.DATA_WIDTH(DW)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #5 clock = ~clock;

   op_pair_type   pending_ops[$];
   gl_result_type expected_results[$];
   int send_idle_pct = 37;
   int recv_idle_pct = 67;
   int error_count = 0;
   int idle_cycles = 0;
   int ops_sent = 0;
   int results_seen = 0;
   int overflow_seen = 0;

   function automatic longint unsigned abs_of(logic [DW-1:0] raw);
      longint unsigned v;
      v = raw;
      if (raw[DW-1])
         v = (64'd1 << DW) - v;
      return v;
   endfunction

   function automatic gl_result_type predict_gcd_lcm(op_pair_type op);
      longint unsigned ma, mb, x, y, r, q, value;
      gl_result_type res;
      ma = abs_of(op.operand_a);
      mb = abs_of(op.operand_b);
      value = 0;
      res.overflow = 1'b0;
      x = ma;
      y = mb;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      if (op.func == gcdlcm_pkg::FUNC_GCD) begin
         if (x > SAT_MAX) begin
            value = SAT_MAX;
            res.overflow = 1'b1;
         end else begin
            value = x;
         end
      end else if (ma != 0 && mb != 0) begin
         q = ma / x;
         if (q > SAT_MAX / mb) begin
            value = SAT_MAX;
            res.overflow = 1'b1;
         end else begin
            value = q * mb;
         end
      end
      res.result = value[DW-2:0];
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.func      <= gcdlcm_pkg::FUNC_GCD;
         req_ch.operand_a <= '0;
         req_ch.operand_b <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid)
            ops_sent <= ops_sent + 1;
         if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            op_pair_type op;
            op = pending_ops.pop_front();
            expected_results.push_back(predict_gcd_lcm(op));
            req_ch.valid     <= 1'b1;
            req_ch.func      <= op.func;
            req_ch.operand_a <= op.operand_a;
            req_ch.operand_b <= op.operand_b;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
               $error("unexpected result item: result=%0d overflow=%0b",
                      rsp_ch.result, rsp_ch.overflow);
               error_count = error_count + 1;
            end else begin
               gl_result_type want;
               want = expected_results.pop_front();
               if (want.overflow)
                  overflow_seen <= overflow_seen + 1;
               if (rsp_ch.result !== want.result) begin
                  $error("result mismatch: expected %0d actual %0d",
                         want.result, rsp_ch.result);
                  error_count = error_count + 1;
               end
               if (rsp_ch.overflow !== want.overflow) begin
                  $error("overflow mismatch: expected %0b actual %0b",
                         want.overflow, rsp_ch.overflow);
                  error_count = error_count + 1;
               end
            end
         end
      end
   end

   // watchdog on cycles with no accepted item
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d results outstanding",
                     expected_results.size());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   function automatic logic [DW-1:0] rand_operand();
      logic [DW-1:0] v;
      case ($urandom_range(7))
         0: v = $urandom_range(20);
         1: v = -$urandom_range(20);
         2: v = {1'b1, {(DW-1){1'b0}}};
         3: v = $urandom & 32'h0000_ffff;
         4: v = ($urandom_range(1000) + 1) * (1 << $urandom_range(12));
         5: v = {DW{1'b0}} | (1 << $urandom_range(DW - 1));
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic add_op(logic func, logic [DW-1:0] a, logic [DW-1:0] b);
      op_pair_type op;
      op.func = func;
      op.operand_a = a;
      op.operand_b = b;
      pending_ops.push_back(op);
   endtask

   task automatic add_random(int n);
      logic [DW-1:0] a, b, k;
      for (int i = 0; i < n; i++) begin
         a = rand_operand();
         b = rand_operand();
         // sometimes force a shared factor so gcd is nontrivial
         if ($urandom_range(3) == 0) begin
            k = $urandom_range(5000) + 1;
            a = ($urandom_range(30000) + 1) * k;
            b = ($urandom_range(30000) + 1) * k;
            if ($urandom_range(1)) a = -a;
            if ($urandom_range(1)) b = -b;
         end
         add_op($urandom_range(1) ? gcdlcm_pkg::FUNC_LCM : gcdlcm_pkg::FUNC_GCD, a, b);
      end
   endtask

   task automatic wait_drained();
      while (pending_ops.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      logic [DW-1:0] most_neg, most_pos;
      most_neg = {1'b1, {(DW-1){1'b0}}};
      most_pos = {1'b0, {(DW-1){1'b1}}};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed corner cases for both operations
      for (int f = 0; f < 2; f++) begin
         add_op(f[0], '0, '0);
         add_op(f[0], 32'd12, '0);
         add_op(f[0], '0, -32'd18);
         add_op(f[0], most_neg, '0);
         add_op(f[0], most_neg, most_neg);
         add_op(f[0], most_neg, 32'd6);
         add_op(f[0], most_pos, most_pos);
         add_op(f[0], most_pos, -32'd1);
         add_op(f[0], -32'd1, 32'hffff_ffff);
         add_op(f[0], 32'd65536, 32'd65537);
         add_op(f[0], 32'd46341, 32'd46340);
         add_op(f[0], -32'd84, 32'd36);
      end
      add_random(600);
      wait_drained();

      send_idle_pct = 67;
      recv_idle_pct = 37;
      add_random(700);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random(700);
      wait_drained();
      repeat (PIPE_DEPTH + 20) @(posedge clock);

      $display("sent %0d items, checked %0d results, %0d saturated",
               ops_sent, results_seen, overflow_seen);
      $display("zero, most negative and large-lcm operands under three stall mixes");
      if (error_count == 0 && expected_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> sim.f
hdl/gcdlcm_pkg.sv
hdl/gcdlcm_req_if.sv
hdl/gcdlcm_rsp_if.sv
hdl/gcdlcm_gcd_step.sv
hdl/gcdlcm_div_step.sv
hdl/integer_gcd_lcm_unit.sv
dv/integer_gcd_lcm_unit_tb.sv
